[hdl/tcgr_pkg.sv]
// Shared constants for the text console glyph renderer.
`default_nettype none
package tcgr_pkg;

	typedef enum logic [1:0] {
		OP_CHAR = 2'd0,
		OP_HOME = 2'd1,
		OP_LOAD = 2'd2
	} op_t;

	typedef enum logic {
		REG_FG = 1'b0,
		REG_BG = 1'b1
	} reg_idx_t;

	localparam logic [7:0] CODE_BS    = 8'h08;
	localparam logic [7:0] CODE_TAB   = 8'h09;
	localparam logic [7:0] CODE_NL    = 8'h0A;
	localparam logic [7:0] CODE_CR    = 8'h0D;
	localparam int         CODE_SPACE = 32;

	localparam logic [15:0] FG_RESET = 16'hFFFF;
	localparam logic [15:0] BG_RESET = 16'h0000;

	localparam logic [2:0] LAST_GLYPH_ROW = 3'd7;
	localparam logic [3:0] TAB_STOP       = 4'd8;

endpackage
`default_nettype wire

[hdl/tcgr_cmd_if.sv]
// Command channel: character, cursor home and font load transactions.
`default_nettype none
interface tcgr_cmd_if;
	logic       valid;
	logic       ready;
	logic [1:0] op;
	logic [7:0] char_code;
	logic [9:0] font_addr;
	logic [7:0] font_row;

	modport source(output valid, op, char_code, font_addr, font_row, input ready);
	modport sink(input valid, op, char_code, font_addr, font_row, output ready);
endinterface
`default_nettype wire

[hdl/tcgr_pix_if.sv]
// Pixel channel: one row write of eight pixels per transaction.
`default_nettype none
interface tcgr_pix_if;
	logic        valid;
	logic        ready;
	logic [8:0]  pixel_x;
	logic [7:0]  pixel_y;
	logic [15:0] color_0;
	logic [15:0] color_1;
	logic [15:0] color_2;
	logic [15:0] color_3;
	logic [15:0] color_4;
	logic [15:0] color_5;
	logic [15:0] color_6;
	logic [15:0] color_7;
	logic        last_row;

	modport source(output valid, pixel_x, pixel_y, color_0, color_1, color_2, color_3,
		color_4, color_5, color_6, color_7, last_row, input ready);
	modport sink(input valid, pixel_x, pixel_y, color_0, color_1, color_2, color_3,
		color_4, color_5, color_6, color_7, last_row, output ready);
endinterface
`default_nettype wire

[hdl/text_console_glyph_renderer_core.sv]
// Text console glyph renderer: 8x8 character generator with cursor and glyph store.
//
// cmd carries one transaction per command: op 0 draws or interprets char_code,
// op 1 homes the cursor, op 2 writes font_row into the glyph store at font_addr.
// pix carries row writes: the x,y of the leftmost pixel and eight colors;
// last_row marks the final row write of a command.
// cfg_we/cfg_index/cfg_data set fg_color (index 0) and bg_color (index 1).
// cmd.ready is high only while the sequencer is idle. Font loads, cursor moves
// and ignored codes are handled in the idle state. A drawn glyph takes a wrap
// and clip check, then for each row a store read, an output load and a send;
// a tab draws up to 8 glyphs. Each row goes through the glyph store read and
// the output register, one after the other, before it is sent.
// When pix.ready is low the row write is held and the sequencer waits.
// Reset clears the cursor and the colors to white on black; the glyph store is
// not cleared and must be loaded before use.
`default_nettype none
module text_console_glyph_renderer_core #(
	parameter int SCREEN_WIDTH  = 320,
	parameter int SCREEN_HEIGHT = 240,
	parameter int FIRST_CODE    = 32,
	parameter int GLYPH_COUNT   = 96
) (
	input  wire         clk,
	input  wire         arst_n,
	tcgr_cmd_if.sink    cmd,
	tcgr_pix_if.source  pix,
	input  wire         cfg_we,
	input  wire         cfg_index,
	input  wire  [15:0] cfg_data
);

	localparam int TEXT_COLS   = SCREEN_WIDTH / 8;
	localparam int TEXT_ROWS   = SCREEN_HEIGHT / 8;
	localparam int COL_W       = $clog2(TEXT_COLS + 1);
	localparam int ROW_W       = $clog2(TEXT_ROWS + 1);
	localparam int STORE_DEPTH = GLYPH_COUNT * 8;
	localparam int ADDR_W      = $clog2(STORE_DEPTH);
	localparam bit SPACE_OK    = (tcgr_pkg::CODE_SPACE >= FIRST_CODE) &&
		(tcgr_pkg::CODE_SPACE < FIRST_CODE + GLYPH_COUNT);
	localparam int SPACE_BASE  = SPACE_OK ? (tcgr_pkg::CODE_SPACE - FIRST_CODE) * 8 : 0;

	typedef enum logic [2:0] {
		S_IDLE,
		S_GLYPH,
		S_FETCH,
		S_LOAD,
		S_SEND
	} state_t;

	state_t             state_q;
	logic [COL_W-1:0]   col_q;
	logic [ROW_W-1:0]   row_q;
	logic [ADDR_W-1:0]  base_q;
	logic [2:0]         rrow_q;
	logic [3:0]         spaces_q;
	logic               bs_q;
	logic [15:0]        fg_q;
	logic [15:0]        bg_q;

	logic [7:0]         store_q [STORE_DEPTH];
	logic [7:0]         rdata_q;
	logic [ADDR_W-1:0]  rd_addr;

	logic               out_valid_q;
	logic [8:0]         out_x_q;
	logic [7:0]         out_y_q;
	logic [15:0]        out_color_q [8];
	logic               out_last_q;

	logic               cmd_fire;
	logic               store_we;
	logic [8:0]         code_ext;
	logic               code_in_font;
	logic [ROW_W-1:0]   row_inc;
	logic               last_glyph;

	assign cmd.ready    = (state_q == S_IDLE);
	assign cmd_fire     = cmd.valid && cmd.ready;
	assign store_we     = cmd_fire && (cmd.op == tcgr_pkg::OP_LOAD) &&
		(int'(cmd.font_addr) < STORE_DEPTH);
	assign code_ext     = {1'b0, cmd.char_code};
	assign code_in_font = (code_ext >= 9'(FIRST_CODE)) &&
		(code_ext < 9'(FIRST_CODE + GLYPH_COUNT));
	assign row_inc      = (row_q < ROW_W'(TEXT_ROWS)) ? row_q + 1'b1 : row_q;
	assign rd_addr      = base_q + ADDR_W'(rrow_q);
	assign last_glyph   = bs_q || (spaces_q == 4'd1) ||
		((col_q >= COL_W'(TEXT_COLS - 1)) && (row_q >= ROW_W'(TEXT_ROWS - 1)));

	always_ff @(posedge clk) begin
		if (store_we) begin
			store_q[ADDR_W'(cmd.font_addr)] <= cmd.font_row;
		end
		rdata_q <= store_q[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fg_q <= tcgr_pkg::FG_RESET;
			bg_q <= tcgr_pkg::BG_RESET;
		end else if (cfg_we) begin
			case (tcgr_pkg::reg_idx_t'(cfg_index))
				tcgr_pkg::REG_FG: fg_q <= cfg_data;
				tcgr_pkg::REG_BG: bg_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_LOAD) begin
			out_x_q    <= 9'({col_q, 3'b000});
			out_y_q    <= 8'({row_q, rrow_q});
			out_last_q <= (rrow_q == tcgr_pkg::LAST_GLYPH_ROW) && last_glyph;
			for (int i = 0; i < 8; i++) begin
				out_color_q[i] <= rdata_q[7 - i] ? fg_q : bg_q;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			col_q       <= '0;
			row_q       <= '0;
			base_q      <= '0;
			rrow_q      <= '0;
			spaces_q    <= '0;
			bs_q        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (cmd_fire) begin
						case (tcgr_pkg::op_t'(cmd.op))
							tcgr_pkg::OP_HOME: begin
								col_q <= '0;
								row_q <= '0;
							end
							tcgr_pkg::OP_CHAR: begin
								case (cmd.char_code)
									tcgr_pkg::CODE_BS: begin
										if (col_q != '0) begin
											col_q <= col_q - 1'b1;
											if (SPACE_OK && (row_q < ROW_W'(TEXT_ROWS))) begin
												bs_q     <= 1'b1;
												spaces_q <= 4'd1;
												base_q   <= ADDR_W'(SPACE_BASE);
												state_q  <= S_GLYPH;
											end
										end
									end
									tcgr_pkg::CODE_TAB: begin
										if (SPACE_OK) begin
											bs_q     <= 1'b0;
											spaces_q <= tcgr_pkg::TAB_STOP - {1'b0, 3'(col_q)};
											base_q   <= ADDR_W'(SPACE_BASE);
											state_q  <= S_GLYPH;
										end
									end
									tcgr_pkg::CODE_NL: begin
										row_q <= row_inc;
										col_q <= '0;
									end
									tcgr_pkg::CODE_CR: begin
										col_q <= '0;
									end
									default: begin
										if (code_in_font) begin
											bs_q     <= 1'b0;
											spaces_q <= 4'd1;
											base_q   <= ADDR_W'({cmd.char_code - 8'(FIRST_CODE),
												3'b000});
											state_q  <= S_GLYPH;
										end
									end
								endcase
							end
							default: ;
						endcase
					end
				end
				S_GLYPH: begin
					rrow_q <= '0;
					if (col_q >= COL_W'(TEXT_COLS)) begin
						col_q <= '0;
						row_q <= row_inc;
						state_q <= (row_inc >= ROW_W'(TEXT_ROWS)) ? S_IDLE : S_FETCH;
					end else begin
						state_q <= (row_q >= ROW_W'(TEXT_ROWS)) ? S_IDLE : S_FETCH;
					end
				end
				S_FETCH: begin
					state_q <= S_LOAD;
				end
				S_LOAD: begin
					out_valid_q <= 1'b1;
					state_q     <= S_SEND;
				end
				S_SEND: begin
					if (pix.ready) begin
						out_valid_q <= 1'b0;
						if (rrow_q == tcgr_pkg::LAST_GLYPH_ROW) begin
							if (!bs_q) begin
								col_q <= col_q + 1'b1;
							end
							spaces_q <= spaces_q - 1'b1;
							state_q  <= (spaces_q > 4'd1) ? S_GLYPH : S_IDLE;
						end else begin
							rrow_q  <= rrow_q + 1'b1;
							state_q <= S_FETCH;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign pix.valid    = out_valid_q;
	assign pix.pixel_x  = out_x_q;
	assign pix.pixel_y  = out_y_q;
	assign pix.color_0  = out_color_q[0];
	assign pix.color_1  = out_color_q[1];
	assign pix.color_2  = out_color_q[2];
	assign pix.color_3  = out_color_q[3];
	assign pix.color_4  = out_color_q[4];
	assign pix.color_5  = out_color_q[5];
	assign pix.color_6  = out_color_q[6];
	assign pix.color_7  = out_color_q[7];
	assign pix.last_row = out_last_q;

	a_valid_in_send: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (state_q == S_SEND))
		else $error("row write valid outside send state");

	a_cursor_bounds: assert property (@(posedge clk) disable iff (!arst_n)
		(col_q <= COL_W'(TEXT_COLS)) && (row_q <= ROW_W'(TEXT_ROWS)))
		else $error("cursor out of range");

	a_spaces_live: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != S_IDLE) |-> (spaces_q != 4'd0))
		else $error("sequencer busy with no glyph pending");

	a_send_clipless: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_LOAD) |-> (row_q < ROW_W'(TEXT_ROWS)) && (col_q < COL_W'(TEXT_COLS)))
		else $error("row write loaded at clipped cursor");

endmodule
`default_nettype wire
